// File: rtl/tensor_offset_greedy_planner_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy offset planner
// Shared property forms: implication now, implication next cycle.
// ----------------------------------------------------------------------------
`ifndef TENSOR_OFFSET_GREEDY_PLANNER_TOP_MACROS_SVH
`define TENSOR_OFFSET_GREEDY_PLANNER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TOGP_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("planner assertion failed");

// antecedent implies consequent in the next cycle
`define TOGP_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("planner assertion failed");

`endif

// File: rtl/togp_pkg.sv
// ----------------------------------------------------------------------------
// togp_pkg
// Types and constants of the greedy offset planner.
// ----------------------------------------------------------------------------
package togp_pkg;

  localparam int STEP_W = 10;
  localparam int SIZE_W = 32;
  localparam int OFS_W  = 40;

  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2
  } togp_status_t;

  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_CLEAR = 1'b1
  } togp_cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] first;
    logic [STEP_W-1:0] last;
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } togp_entry_t;

endpackage

// File: rtl/tensor_offset_greedy_planner_top.sv
// ----------------------------------------------------------------------------
// tensor_offset_greedy_planner_top
// Best-fit offset planner over an offset-ordered table of live buffers.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_command, in_first_step,
//          |           | in_last_step, in_block_size
//  out     | output    | out_valid, out_stall, out_placed_offset,
//          |           | out_peak_footprint, out_status
//
// Place beat: the registered table read sets its pace (read and evaluate per
// scanned entry, a calc step, then check, read and write per shifted entry).
// Overflow beats end after the scan and the calc step. Clear and table-full
// beats finish straight from idle. One beat is in flight at a time.
// rst_n is synchronous; it empties the table (count and footprint to zero).
// A result holds on the out ports while out_stall is high; no new beat is
// taken until it leaves.
// ----------------------------------------------------------------------------
`include "tensor_offset_greedy_planner_top_macros.svh"

module tensor_offset_greedy_planner_top #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_STEPS   = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [togp_pkg::STEP_W-1:0]   in_first_step,
  input  logic [togp_pkg::STEP_W-1:0]   in_last_step,
  input  logic [togp_pkg::SIZE_W-1:0]   in_block_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [togp_pkg::OFS_W-1:0]    out_placed_offset,
  output logic [togp_pkg::OFS_W-1:0]    out_peak_footprint,
  output logic [1:0]                    out_status
);
  import togp_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = AW + 1;
  localparam int SMAXI = (MAX_STEPS - 1 > 1023) ? 1023 : MAX_STEPS - 1;
  localparam logic [STEP_W-1:0] STEP_MAX = SMAXI[STEP_W-1:0];
  localparam logic [CW-1:0] CNT_MAX = MAX_ENTRIES[CW-1:0];

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_CALC, S_SHIFT_CHK, S_SHIFT_RD, S_SHIFT_EV
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r, idx_r;
  logic [OFS_W-1:0]  fp_r, run_end_r, best_r, best_gap_r;
  logic              found_r;
  logic [STEP_W-1:0] first_r, last_r;
  logic [SIZE_W-1:0] size_r;
  logic              out_valid_r;
  logic [OFS_W-1:0]  out_ofs_r, out_peak_r;
  togp_status_t      out_st_r;

  togp_entry_t       mem [MAX_ENTRIES];
  togp_entry_t       rd_q_r, wdata;
  logic [AW-1:0]     raddr, waddr;
  logic              we;

  logic              accept;
  logic [STEP_W-1:0] first_c, last_c, lo, hi;
  logic              ovl, fits;
  logic [OFS_W-1:0]  gap, e_end, best_fin;
  logic [OFS_W:0]    end_sum;
  logic [CW-1:0]     idx_m1;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_placed_offset = out_ofs_r;
  assign out_peak_footprint = out_peak_r;
  assign out_status = out_st_r;

  assign first_c = (in_first_step > STEP_MAX) ? STEP_MAX : in_first_step;
  assign last_c  = (in_last_step > STEP_MAX) ? STEP_MAX : in_last_step;

  assign lo    = (first_r > rd_q_r.first) ? first_r : rd_q_r.first;
  assign hi    = (last_r < rd_q_r.last) ? last_r : rd_q_r.last;
  assign ovl   = lo <= hi;
  assign gap   = rd_q_r.offset - run_end_r;
  assign fits  = (rd_q_r.offset >= run_end_r) && (gap >= {8'd0, size_r})
                 && (!found_r || gap < best_gap_r);
  assign e_end = rd_q_r.offset + {8'd0, rd_q_r.size};

  assign best_fin = found_r ? best_r : run_end_r;
  assign end_sum  = {1'b0, best_fin} + {9'd0, size_r};
  assign idx_m1   = idx_r - 1'b1;

  always_comb begin
    raddr = idx_r[AW-1:0];
    if (state_r == S_SHIFT_RD) begin
      raddr = idx_m1[AW-1:0];
    end
    waddr = idx_r[AW-1:0];
    we = 1'b0;
    wdata = '{first: first_r, last: last_r, offset: best_r, size: size_r};
    if (state_r == S_SHIFT_CHK && idx_r == '0) begin
      we = 1'b1;
    end else if (state_r == S_SHIFT_EV) begin
      we = 1'b1;
      if (rd_q_r.offset > best_r) begin
        wdata = rd_q_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            first_r    <= first_c;
            last_r     <= last_c;
            size_r     <= in_block_size;
            run_end_r  <= '0;
            best_r     <= '0;
            best_gap_r <= '0;
            found_r    <= 1'b0;
            idx_r      <= '0;
            if (in_command == CMD_CLEAR) begin
              cnt_r       <= '0;
              fp_r        <= '0;
              out_valid_r <= 1'b1;
              out_ofs_r   <= '0;
              out_peak_r  <= '0;
              out_st_r    <= ST_OK;
            end else if (cnt_r >= CNT_MAX) begin
              out_valid_r <= 1'b1;
              out_ofs_r   <= '0;
              out_peak_r  <= fp_r;
              out_st_r    <= ST_FULL;
            end else begin
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state_r <= (idx_r == cnt_r) ? S_CALC : S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (ovl) begin
            if (fits) begin
              best_gap_r <= gap;
              best_r     <= run_end_r;
              found_r    <= 1'b1;
            end
            if (e_end > run_end_r) begin
              run_end_r <= e_end;
            end
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= S_SCAN_RD;
        end
        S_CALC: begin
          best_r <= best_fin;
          if (end_sum[OFS_W]) begin
            fp_r        <= OFS_MAX;
            out_valid_r <= 1'b1;
            out_ofs_r   <= best_fin;
            out_peak_r  <= OFS_MAX;
            out_st_r    <= ST_OVERFLOW;
            state_r     <= S_IDLE;
          end else begin
            idx_r   <= cnt_r;
            state_r <= S_SHIFT_CHK;
          end
        end
        S_SHIFT_CHK: begin
          state_r <= (idx_r == '0) ? S_IDLE : S_SHIFT_RD;
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_EV;
        end
        S_SHIFT_EV: begin
          if (rd_q_r.offset > best_r) begin
            idx_r   <= idx_m1;
            state_r <= S_SHIFT_CHK;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (we && wdata.offset == best_r && !(state_r == S_SHIFT_EV
          && rd_q_r.offset > best_r)) begin
        cnt_r       <= cnt_r + 1'b1;
        out_valid_r <= 1'b1;
        out_ofs_r   <= best_r;
        out_peak_r  <= (end_sum[OFS_W-1:0] > fp_r) ? end_sum[OFS_W-1:0] : fp_r;
        fp_r        <= (end_sum[OFS_W-1:0] > fp_r) ? end_sum[OFS_W-1:0] : fp_r;
        out_st_r    <= ST_OK;
      end
    end
  end

  `TOGP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX)
  `TOGP_ASSERT_IMP(a_wr_in_table, we, idx_r <= cnt_r)
  `TOGP_ASSERT_NEXT(a_clear_empties, accept && in_command == CMD_CLEAR, cnt_r == '0)
  `TOGP_ASSERT_IMP(a_peak_covers, out_valid_r && out_st_r == ST_OK,
                   out_peak_r >= out_ofs_r)

endmodule
